[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge and disabled while reset is low.
`define ARP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge and disabled while reset is low.
`define ARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/arp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // ELF ARM relocation type numbers.
  localparam logic [7:0] TYPE_NONE    = 8'd0;
  localparam logic [7:0] TYPE_ABS32   = 8'd2;
  localparam logic [7:0] TYPE_REL32   = 8'd3;
  localparam logic [7:0] TYPE_TARGET1 = 8'd38;
  localparam logic [7:0] TYPE_PREL31  = 8'd42;
  localparam logic [7:0] TYPE_MOVW    = 8'd47;
  localparam logic [7:0] TYPE_MOVT    = 8'd48;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  // Thumb MOVW/MOVT encoding constants.
  localparam logic [15:0] MOVW_PATTERN  = 16'hF240;
  localparam logic [15:0] MOVT_PATTERN  = 16'hF2C0;
  localparam logic [15:0] MOV_OPC_MASK  = 16'hFBF0;
  localparam logic [15:0] MOV_HI_RSVD   = 16'h8000;
  localparam logic [15:0] MOV_LO_KEEP   = 16'hFBE0;
  localparam logic [15:0] MOV_HI_KEEP   = 16'h8F00;

  typedef struct packed {
    logic [31:0] patched_word;
    status_t     status;
  } patch_result_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] site_word;
    logic [31:0] symbol_value;
    logic [31:0] site_address;
  } patch_request_t;

endpackage

`default_nettype wire

[hdl/arp_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface arp_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [31:0] site_word;
  logic [31:0] symbol_value;
  logic [31:0] site_address;

  modport source (output valid, output opcode, output site_word, output symbol_value,
                  output site_address, input ready);
  modport sink   (input valid, input opcode, input site_word, input symbol_value,
                  input site_address, output ready);
endinterface

interface arp_res_if;
  logic             valid;
  logic             ready;
  logic [31:0]      patched_word;
  arp_pkg::status_t status;

  modport source (output valid, output patched_word, output status, input ready);
  modport sink   (input valid, input patched_word, input status, output ready);
endinterface

`default_nettype wire

[hdl/arp_patch_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module arp_patch_unit (
  input  arp_pkg::patch_request_t req,
  output arp_pkg::patch_result_t  res
);

  logic [15:0] lo;
  logic [15:0] hi;
  logic [31:0] sum_abs;
  logic [31:0] sum_rel;
  logic [31:0] prel_x;
  logic [15:0] mov_imm;
  logic [31:0] mov_v;
  logic [15:0] mov_half;
  logic [15:0] mov_pat;
  logic        mov_bad;
  logic [31:0] mov_word;

  assign lo = req.site_word[15:0];
  assign hi = req.site_word[31:16];

  assign sum_abs = req.symbol_value + req.site_word;
  assign sum_rel = sum_abs - req.site_address;
  // PREL31 addend is the low 31 bits, sign-extended from bit 30.
  assign prel_x  = req.symbol_value + {req.site_word[30], req.site_word[30:0]}
                   - req.site_address;

  // imm16 = imm4:i:imm3:imm8, taken as a signed addend.
  assign mov_imm  = {lo[3:0], lo[10], hi[14:12], hi[7:0]};
  assign mov_v    = req.symbol_value + {{16{mov_imm[15]}}, mov_imm};
  assign mov_half = (req.opcode == arp_pkg::TYPE_MOVT) ? mov_v[31:16] : mov_v[15:0];
  assign mov_pat  = (req.opcode == arp_pkg::TYPE_MOVT) ? arp_pkg::MOVT_PATTERN
                                                       : arp_pkg::MOVW_PATTERN;
  assign mov_bad  = ((lo & arp_pkg::MOV_OPC_MASK) != mov_pat) ||
                    ((hi & arp_pkg::MOV_HI_RSVD) != 16'h0000);
  assign mov_word = {(hi & arp_pkg::MOV_HI_KEEP) | {1'b0, mov_half[10:8], 4'h0, mov_half[7:0]},
                     (lo & arp_pkg::MOV_LO_KEEP) | {5'h00, mov_half[11], 6'h00,
                                                     mov_half[15:12]}};

  always_comb begin
    res.patched_word = req.site_word;
    res.status       = arp_pkg::ST_OK;
    case (req.opcode)
      arp_pkg::TYPE_NONE: begin
      end
      arp_pkg::TYPE_ABS32, arp_pkg::TYPE_TARGET1: begin
        res.patched_word = sum_abs;
      end
      arp_pkg::TYPE_REL32: begin
        res.patched_word = sum_rel;
      end
      arp_pkg::TYPE_PREL31: begin
        if (prel_x[31] != prel_x[30]) begin
          res.status = arp_pkg::ST_OVERFLOW;
        end else begin
          res.patched_word = {req.site_word[31], prel_x[30:0]};
        end
      end
      arp_pkg::TYPE_MOVW, arp_pkg::TYPE_MOVT: begin
        if (mov_bad) begin
          res.status = arp_pkg::ST_INVALID;
        end else begin
          res.patched_word = mov_word;
        end
      end
      default: begin
        res.status = arp_pkg::ST_UNSUPPORTED;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/arm_relocation_patcher.sv]
// An accepted request passes the input register, then the result register.
// Throughput: one item per cycle unless out_res stalls; patch arithmetic
// sits between those registers, and each stage frees as it hands on.
// Reset: synchronous, active low; it empties both stages. Payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module arm_relocation_patcher (
  input  logic       clk,
  input  logic       rst_n,
  arp_req_if.sink    in_req,
  arp_res_if.source  out_res
);

  // Stage one: the registered request.
  logic                    req_valid_r;
  arp_pkg::patch_request_t req_r;

  // Stage two: the registered result that faces the sink.
  logic                    res_valid_r;
  arp_pkg::patch_result_t  res_r;

  arp_pkg::patch_result_t  res_nxt;
  logic                    res_load;
  logic                    req_load;

  // The result register takes a new item whenever it is empty or its item
  // is being taken in this cycle.
  assign res_load = !res_valid_r || out_res.ready;

  // The request register frees when its item moves on, so a new item can
  // enter every cycle while the sink keeps up, and one more is held while
  // a finished result waits.
  assign req_load      = !req_valid_r || res_load;
  assign in_req.ready  = req_load;

  arp_patch_unit u_patch (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (req_load) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_load && in_req.valid) begin
      req_r.opcode       <= in_req.opcode;
      req_r.site_word    <= in_req.site_word;
      req_r.symbol_value <= in_req.symbol_value;
      req_r.site_address <= in_req.site_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= req_valid_r;
    end
  end

  // The result is captured only when a request moves over, so a stalled
  // result holds its value.
  always_ff @(posedge clk) begin
    if (res_load && req_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = res_valid_r;
  assign out_res.patched_word = res_r.patched_word;
  assign out_res.status       = res_r.status;

endmodule

`default_nettype wire

[hdl/arp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module arp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [31:0]      out_patched_word,
  input arp_pkg::status_t out_status
);

  `ARP_ASSERT_IMPL(a_empty_after_reset, clk, rst_n, $rose(rst_n), !out_valid)
  `ARP_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_patched_word) && $stable(out_status))
  `ARP_ASSERT_NEXT(a_two_cycle_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready, out_valid)
  `ARP_ASSERT_IMPL(a_no_invented_item, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind arm_relocation_patcher arp_checker u_arp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_patched_word (out_res.patched_word),
  .out_status       (out_res.status)
);

`default_nettype wire
